>>> src/pts_pkg.sv
package pts_pkg;

  localparam int DEF_NUM_TASKS = 8;
  localparam int DEF_TIME_BITS = 16;
  localparam int FIELD_W       = 16;
  localparam int MASK_W        = 8;
  localparam int SEL_W         = 3;
  localparam int POLICY_W      = 2;

  localparam logic [POLICY_W-1:0] POL_EDF = 2'd0;
  localparam logic [POLICY_W-1:0] POL_SRT = 2'd1;
  localparam logic [POLICY_W-1:0] POL_LST = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [SEL_W-1:0]   task_index;
    logic [FIELD_W-1:0] exec_time;
    logic [FIELD_W-1:0] period_len;
    logic [FIELD_W-1:0] deadline_rel;
  } item_t;

  typedef struct packed {
    logic              selected_valid;
    logic [SEL_W-1:0]  selected_task;
    logic [MASK_W-1:0] completed_mask;
    logic [MASK_W-1:0] missed_mask;
    logic [MASK_W-1:0] overrun_mask;
  } result_t;

  typedef struct packed {
    logic completed;
    logic missed;
    logic overrun;
    logic candidate;
  } upd_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

>>> src/pts_upd.sv
module pts_upd
  import pts_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                        tick,
  input  logic                        charge_hit,
  input  logic [POLICY_W-1:0]         policy,
  input  logic [TIME_BITS-1:0]        exec_in,
  input  logic [TIME_BITS-1:0]        period_in,
  input  logic [TIME_BITS-1:0]        deadline_in,
  input  logic [TIME_BITS-1:0]        rem_in,
  input  logic [TIME_BITS-1:0]        elapsed_in,
  input  logic                        done_in,
  output logic [TIME_BITS-1:0]        rem_out,
  output logic [TIME_BITS-1:0]        elapsed_out,
  output logic                        done_out,
  output upd_flags_t                  flags,
  output logic signed [TIME_BITS+1:0] key
);

  logic [TIME_BITS-1:0] elapsed_inc;
  logic [TIME_BITS-1:0] rem_dec;
  logic                 hit;
  logic                 done_chg;
  logic                 period_end;
  logic signed [TIME_BITS+1:0] d_ext;
  logic signed [TIME_BITS+1:0] e_ext;
  logic signed [TIME_BITS+1:0] r_ext;

  always_comb begin
    elapsed_inc = elapsed_in + TIME_BITS'(1);
    hit         = tick && charge_hit && !done_in && (rem_in != '0);
    rem_dec     = rem_in - TIME_BITS'(hit);
    done_chg    = done_in || (hit && (rem_dec == '0));
    period_end  = tick && (elapsed_inc >= period_in);

    flags.completed = hit && (rem_dec == '0);
    flags.missed    = tick && !done_chg && (elapsed_inc >= deadline_in);
    flags.overrun   = period_end && !done_chg;

    if (!tick) begin
      rem_out     = rem_in;
      elapsed_out = elapsed_in;
      done_out    = done_in;
    end else if (period_end) begin
      // period restart
      rem_out     = exec_in;
      elapsed_out = '0;
      done_out    = (exec_in == '0);
    end else begin
      rem_out     = rem_dec;
      elapsed_out = elapsed_inc;
      done_out    = done_chg;
    end
    flags.candidate = !done_out;
  end

  always_comb begin
    d_ext = $signed({2'b00, deadline_in});
    e_ext = $signed({2'b00, elapsed_out});
    r_ext = $signed({2'b00, rem_out});
    case (policy)
      POL_SRT: key = r_ext;
      POL_LST: key = d_ext - e_ext - r_ext;
      default: key = d_ext - e_ext;
    endcase
  end

endmodule

>>> src/periodic_task_scheduler.sv
// a result is registered after a sweep over the task table; a new item is taken only in idle,
// after the result of the last item has been emitted: the sweep reads one
//   table entry per cycle and writes it back on the next, then the update and compare stages
//   drain, the result is emitted and the block returns to idle to take the next transfer
// a result that waits for result_ready holds the block in emit and stalls the input
// reset: valid bits, running task, policy (earliest deadline) and handshake state clear;
//   the task table itself holds no reset value and is only used for loaded entries
module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int NUM_TASKS = DEF_NUM_TASKS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                cfg_we,
  input  logic [POLICY_W-1:0] cfg_wdata
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int ENT_W = 5 * TIME_BITS + 1;
  localparam int KW    = TIME_BITS + 2;

  state_t state, state_next;

  logic [POLICY_W-1:0]  policy;
  logic [NUM_TASKS-1:0] entry_valid;
  logic                 running_valid;
  logic [IDX_W-1:0]     running_index;
  logic                 cur_cmd;

  logic [ENT_W-1:0] mem [NUM_TASKS];
  logic [ENT_W-1:0] mem_rdata;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;

  logic [IDX_W-1:0] rd_idx;
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic             k_valid;
  logic             k_cand;
  logic [IDX_W-1:0] k_idx;
  logic signed [KW-1:0] k_key;

  logic                 best_valid;
  logic [IDX_W-1:0]     best_idx;
  logic signed [KW-1:0] best_key;
  logic [MASK_W-1:0]    comp_mask;
  logic [MASK_W-1:0]    miss_mask;
  logic [MASK_W-1:0]    over_mask;

  logic item_xfer;
  logic scan_on;
  logic last_rd;
  logic emit;
  logic load_ok;
  logic s1_live;

  logic [TIME_BITS-1:0] ex_f, pe_f, dl_f, rm_f, el_f;
  logic                 dn_f;
  logic [TIME_BITS-1:0] rm_n, el_n;
  logic                 dn_n;
  upd_flags_t           flags;
  logic signed [KW-1:0] key;
  logic [TIME_BITS-1:0] ld_exec;

  assign item_xfer = item_valid && item_ready;
  assign last_rd   = (rd_idx == IDX_W'(NUM_TASKS - 1));
  assign load_ok   = (item.cmd == CMD_LOAD) && (32'(item.task_index) < NUM_TASKS);
  assign s1_live   = s1_valid && entry_valid[s1_idx];
  assign ld_exec   = TIME_BITS'(item.exec_time);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (item_xfer) state_next = ST_SCAN;
      ST_SCAN:  if (last_rd) state_next = ST_DRAIN;
      ST_DRAIN: if (!s1_valid && !k_valid) state_next = ST_EMIT;
      ST_EMIT:  if (emit) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    scan_on    = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_SCAN: scan_on = 1'b1;
      ST_EMIT: emit = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_EDF;
    end else if (cfg_we) begin
      policy <= cfg_wdata;
    end
  end

  // table memory: load write at transfer, write back during the sweep
  always_comb begin
    if (item_xfer) begin
      mem_we    = load_ok;
      mem_waddr = IDX_W'(item.task_index);
      mem_wdata = {ld_exec, TIME_BITS'(item.period_len), TIME_BITS'(item.deadline_rel),
                   ld_exec, {TIME_BITS{1'b0}}, (ld_exec == '0)};
    end else begin
      mem_we    = s1_live && (cur_cmd == CMD_TICK);
      mem_waddr = s1_idx;
      mem_wdata = {ex_f, pe_f, dl_f, rm_n, el_n, dn_n};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (scan_on) begin
      mem_rdata <= mem[rd_idx];
    end
  end

  assign {ex_f, pe_f, dl_f, rm_f, el_f, dn_f} = mem_rdata;

  pts_upd #(
    .TIME_BITS (TIME_BITS)
  ) u_upd (
    .tick        (cur_cmd == CMD_TICK),
    .charge_hit  (running_valid && (running_index == s1_idx)),
    .policy      (policy),
    .exec_in     (ex_f),
    .period_in   (pe_f),
    .deadline_in (dl_f),
    .rem_in      (rm_f),
    .elapsed_in  (el_f),
    .done_in     (dn_f),
    .rem_out     (rm_n),
    .elapsed_out (el_n),
    .done_out    (dn_n),
    .flags       (flags),
    .key         (key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (item_xfer && load_ok) begin
      entry_valid[IDX_W'(item.task_index)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      cur_cmd <= item.cmd;
    end
  end

  // sweep pipeline: read, update, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      s1_valid <= 1'b0;
      k_valid  <= 1'b0;
    end else begin
      rd_idx   <= scan_on ? (last_rd ? '0 : rd_idx + IDX_W'(1)) : '0;
      s1_valid <= scan_on;
      k_valid  <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= rd_idx;
    k_idx  <= s1_idx;
    k_key  <= key;
    k_cand <= s1_live && flags.candidate;
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      best_valid <= 1'b0;
      best_idx   <= '0;
      best_key   <= '0;
      comp_mask  <= '0;
      miss_mask  <= '0;
      over_mask  <= '0;
    end else begin
      if (k_valid && k_cand && (!best_valid || (k_key < best_key))) begin
        best_valid <= 1'b1;
        best_idx   <= k_idx;
        best_key   <= k_key;
      end
      // only the first eight tasks are reported
      if (s1_live && (32'(s1_idx) < MASK_W)) begin
        comp_mask[SEL_W'(s1_idx)] <= flags.completed;
        miss_mask[SEL_W'(s1_idx)] <= flags.missed;
        over_mask[SEL_W'(s1_idx)] <= flags.overrun;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_valid <= 1'b0;
      running_index <= '0;
    end else if (emit) begin
      running_valid <= best_valid;
      running_index <= best_valid ? best_idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.selected_valid <= best_valid;
      result.selected_task  <= best_valid ? SEL_W'(best_idx) : '0;
      result.completed_mask <= comp_mask;
      result.missed_mask    <= miss_mask;
      result.overrun_mask   <= over_mask;
    end
  end

`ifndef ASSERT_OFF
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    item_xfer |-> !s1_valid && !k_valid)
    else $error("item transfer while sweep active");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared outside emit");

  a_wb_addr: assert property (@(posedge clk) disable iff (rst)
    (mem_we && scan_on) |-> (mem_waddr != rd_idx))
    else $error("write back collides with sweep read");

  a_running_loaded: assert property (@(posedge clk) disable iff (rst)
    running_valid |-> entry_valid[running_index])
    else $error("running task not loaded");
`endif

endmodule
